// File: rtl/tws_pkg.sv
// Shared types, constants and helpers for the three-wire serial master.
package tws_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned SHIFT_BITS = 2 * BYTE_BITS;
  localparam int unsigned TICK_BITS  = 10;
  localparam int unsigned HALF_BITS  = 8;
  localparam int unsigned BITC_BITS  = 5;
  localparam int unsigned TIME_BITS  = 3 * BYTE_BITS;
  localparam int unsigned CFG_BITS   = 10;

  localparam logic [HALF_BITS-1:0] HALF_PERIOD_RST = 8'd18;
  localparam logic [TICK_BITS-1:0] CE_SETUP_RST    = 10'd67;
  localparam logic [TICK_BITS-1:0] TICK_MAX        = 10'd1023;

  localparam logic [BYTE_BITS-1:0] CMD_HOUR = 8'h85;
  localparam logic [BYTE_BITS-1:0] CMD_MIN  = 8'h83;
  localparam logic [BYTE_BITS-1:0] CMD_SEC  = 8'h81;

  // Configuration register indexes
  typedef enum logic {
    CFG_HALF_PERIOD = 1'b0,
    CFG_CE_SETUP    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_TIME  = 2'd3
  } req_e;

  typedef struct packed {
    logic [HALF_BITS-1:0] half_period;
    logic [TICK_BITS-1:0] ce_setup;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [BYTE_BITS-1:0] command;
    logic [BYTE_BITS-1:0] write_data;
    logic                 data_in;
  } tick_t;

  typedef struct packed {
    logic                 ce;
    logic                 sclk;
    logic                 data_out;
    logic                 data_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [TIME_BITS-1:0] read_data;
  } res_t;

  // Command for each read of a time-read sequence (hour, minute, second)
  function automatic logic [BYTE_BITS-1:0] time_cmd(input logic [1:0] k);
    logic [BYTE_BITS-1:0] c;
    unique case (k)
      2'd0:    c = CMD_HOUR;
      2'd1:    c = CMD_MIN;
      default: c = CMD_SEC;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tws_if.sv
// Valid/ready channel interfaces for tick items, results and configuration writes.
interface tws_tick_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [tws_pkg::BYTE_BITS-1:0] command;
  logic [tws_pkg::BYTE_BITS-1:0] write_data;
  logic                          data_in;

  modport source (output valid, req_type, command, write_data, data_in, input ready);
  modport sink   (input valid, req_type, command, write_data, data_in, output ready);
endinterface

interface tws_res_if;
  logic                          valid;
  logic                          ready;
  logic                          ce;
  logic                          sclk;
  logic                          data_out;
  logic                          data_drive;
  logic                          busy_res;
  logic                          done_res;
  logic [tws_pkg::TIME_BITS-1:0] read_data;

  modport source (output valid, ce, sclk, data_out, data_drive, busy_res, done_res,
                  read_data, input ready);
  modport sink   (input valid, ce, sclk, data_out, data_drive, busy_res, done_res,
                  read_data, output ready);
endinterface

interface tws_cfg_if;
  logic                         valid;
  logic                         ready;
  logic                         index;
  logic [tws_pkg::CFG_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/three_wire_serial_master.sv
// Top level of the three-wire serial master: channels, sequencer and output register.
//
// Usage:
//   tick_i  - one transaction per timing tick of the serial link. req_type starts a
//             read, a write or a packed time read when the link is idle (ignored
//             while busy); data_in is the sampled level of the data pin.
//   res_o   - exactly one result transaction per tick transaction: CE, SCLK,
//             data-out and drive-enable levels, busy, done and read data.
//   cfg_i   - register writes (index 0: half period, index 1: CE setup ticks);
//             always ready, write only while the link is idle.
// A result is written into the output register when its tick is accepted.
// Throughput: one tick per cycle unless stalled; the sequencer step is a
// single pass of counter compare and shift logic between state and output
// registers. A new tick is taken in the same cycle the held result is taken.
// Reset: link idle, no result valid, registers at 18 and 67 ticks.
// Stall: while res_o.ready is low and a result is held, tick_i.ready is low
// and the sequencer does not advance.
module three_wire_serial_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  tws_tick_if.sink   tick_i,
  tws_res_if.source  res_o,
  tws_cfg_if.sink    cfg_i
);

  tws_pkg::tick_t tick;
  tws_pkg::cfg_t  cfg;
  tws_pkg::res_t  res_d, res_q;
  logic           out_valid_q;
  logic           in_fire;

  // Config channel never stalls
  assign cfg_i.ready = 1'b1;

  tws_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (tws_pkg::cfg_idx_e'(cfg_i.index)),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  assign tick.req_type   = tick_i.req_type;
  assign tick.command    = tick_i.command;
  assign tick.write_data = tick_i.write_data;
  assign tick.data_in    = tick_i.data_in;

  // Accept when the output register is empty or drains this cycle
  assign tick_i.ready = !out_valid_q || res_o.ready;
  assign in_fire      = tick_i.valid && tick_i.ready;

  tws_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .tick_i (tick),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.ce         = res_q.ce;
  assign res_o.sclk       = res_q.sclk;
  assign res_o.data_out   = res_q.data_out;
  assign res_o.data_drive = res_q.data_drive;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.read_data  = res_q.read_data;

endmodule

// File: rtl/tws_cfg.sv
// Configuration registers: half period and CE setup time.
module tws_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  tws_pkg::cfg_idx_e             idx_i,
  input  logic [tws_pkg::CFG_BITS-1:0]  data_i,
  output tws_pkg::cfg_t                 cfg_o
);

  tws_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        tws_pkg::CFG_HALF_PERIOD: cfg_d.half_period = data_i[tws_pkg::HALF_BITS-1:0];
        tws_pkg::CFG_CE_SETUP:    cfg_d.ce_setup    = data_i[tws_pkg::TICK_BITS-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= tws_pkg::HALF_PERIOD_RST;
      cfg_q.ce_setup    <= tws_pkg::CE_SETUP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tws_engine.sv
// Link sequencer: phase, tick and bit counters, shift registers; one step per tick.
module tws_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  tws_pkg::tick_t tick_i,
  input  tws_pkg::cfg_t  cfg_i,
  output tws_pkg::res_t  res_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_GAP   = 3'd4
  } phase_e;

  phase_e                           phase_d, phase_q;
  logic [tws_pkg::TICK_BITS-1:0]    tick_d, tick_q;
  logic [tws_pkg::BITC_BITS-1:0]    bit_d, bit_q;
  logic [tws_pkg::SHIFT_BITS-1:0]   sout_d, sout_q;
  logic [tws_pkg::BYTE_BITS-1:0]    sin_d, sin_q;
  logic [tws_pkg::TIME_BITS-1:0]    accum_d, accum_q;
  logic [1:0]                       ridx_d, ridx_q;
  tws_pkg::req_e                    kind_d, kind_q;

  logic [tws_pkg::TICK_BITS-1:0]    tick_inc;
  logic [tws_pkg::TICK_BITS-1:0]    half_ext;
  logic                             half_done;
  logic [tws_pkg::TIME_BITS-1:0]    accum_new;
  logic [1:0]                       ridx_new;
  logic [1:0]                       ridx_clip;
  tws_pkg::req_e                    req;
  logic                             done;
  logic [tws_pkg::TIME_BITS-1:0]    result;
  logic                             ce;

  assign req       = tws_pkg::req_e'(tick_i.req_type);
  assign tick_inc  = (tick_q < tws_pkg::TICK_MAX) ? tick_q + 1'b1 : tick_q;
  assign half_ext  = {{(tws_pkg::TICK_BITS-tws_pkg::HALF_BITS){1'b0}}, cfg_i.half_period};
  assign half_done = (tick_inc >= half_ext);
  assign accum_new = {accum_q[tws_pkg::TIME_BITS-tws_pkg::BYTE_BITS-1:0], sin_q};
  assign ridx_new  = ridx_q + 1'b1;
  assign ridx_clip = (ridx_q > 2'd2) ? 2'd2 : ridx_q;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    sout_d  = sout_q;
    sin_d   = sin_q;
    accum_d = accum_q;
    ridx_d  = ridx_q;
    kind_d  = kind_q;
    done    = 1'b0;
    result  = '0;

    unique case (phase_q)
      PH_IDLE: begin
        if (req != tws_pkg::REQ_NONE) begin
          kind_d  = req;
          accum_d = '0;
          ridx_d  = '0;
          sin_d   = '0;
          bit_d   = '0;
          tick_d  = '0;
          phase_d = PH_SETUP;
          priority if (req == tws_pkg::REQ_WRITE) begin
            sout_d = {tick_i.write_data, tick_i.command};
          end else if (req == tws_pkg::REQ_READ) begin
            sout_d = {{tws_pkg::BYTE_BITS{1'b0}}, tick_i.command};
          end else begin
            sout_d = {{tws_pkg::BYTE_BITS{1'b0}}, tws_pkg::time_cmd(2'd0)};
          end
        end
      end
      PH_SETUP: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.ce_setup) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
        end
      end
      PH_HIGH: begin
        tick_d = tick_inc;
        if (half_done) begin
          // Read bits are sampled at the end of the high phase
          if (kind_q != tws_pkg::REQ_WRITE &&
              bit_q >= tws_pkg::BITC_BITS'(tws_pkg::BYTE_BITS)) begin
            sin_d = sin_q | (tws_pkg::BYTE_BITS'(tick_i.data_in) << bit_q[2:0]);
          end else begin
            sout_d = sout_q >> 1;
          end
          bit_d   = bit_q + 1'b1;
          phase_d = PH_LOW;
          tick_d  = '0;
        end
      end
      PH_LOW: begin
        tick_d = tick_inc;
        if (half_done) begin
          tick_d = '0;
          if (bit_q >= tws_pkg::BITC_BITS'(tws_pkg::SHIFT_BITS)) begin
            phase_d = PH_IDLE;
            priority if (kind_q == tws_pkg::REQ_READ) begin
              done   = 1'b1;
              result = {{(tws_pkg::TIME_BITS-tws_pkg::BYTE_BITS){1'b0}}, sin_q};
            end else if (kind_q == tws_pkg::REQ_WRITE) begin
              done = 1'b1;
            end else begin
              accum_d = accum_new;
              ridx_d  = ridx_new;
              if (ridx_new == 2'd3) begin
                done   = 1'b1;
                result = accum_new;
              end else begin
                phase_d = PH_GAP;
              end
            end
          end else begin
            phase_d = PH_HIGH;
          end
        end
      end
      PH_GAP: begin
        tick_d = tick_inc;
        if (half_done) begin
          sout_d  = {{tws_pkg::BYTE_BITS{1'b0}}, tws_pkg::time_cmd(ridx_clip)};
          sin_d   = '0;
          bit_d   = '0;
          tick_d  = '0;
          phase_d = PH_SETUP;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // Pin levels follow the updated state
  assign ce = (phase_d == PH_SETUP) || (phase_d == PH_HIGH) || (phase_d == PH_LOW);
  assign res_o.ce         = ce;
  assign res_o.sclk       = (phase_d == PH_HIGH);
  assign res_o.data_drive = ce && (kind_d == tws_pkg::REQ_WRITE ||
                                   bit_d < tws_pkg::BITC_BITS'(tws_pkg::BYTE_BITS));
  assign res_o.data_out   = res_o.data_drive & sout_d[0];
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.done_res   = done;
  assign res_o.read_data  = result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      sout_q  <= '0;
      sin_q   <= '0;
      accum_q <= '0;
      ridx_q  <= '0;
      kind_q  <= tws_pkg::REQ_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      sout_q  <= sout_d;
      sin_q   <= sin_d;
      accum_q <= accum_d;
      ridx_q  <= ridx_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the three-wire serial master: directed and random tick streams.
module tb;

  // Longest stretch without any transaction on any channel before the run is
  // declared hung. Legitimate quiet stretches are a few cycles (sender gaps,
  // settle time) plus receiver stall runs, so this is far above them.
  localparam int QUIET_LIMIT = 2000;

  // Link sequencer phases, as the predictor tracks them
  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_SETUP,
    LINK_HIGH,
    LINK_LOW,
    LINK_GAP
  } link_phase_e;

  // Scoreboard: steps its own copy of the link sequencer on every accepted
  // tick and queues the pin levels that tick must produce.
  class link_scoreboard;
    logic [tws_pkg::HALF_BITS-1:0]  half_period;
    logic [tws_pkg::TICK_BITS-1:0]  ce_setup;
    link_phase_e                    phase;
    logic [tws_pkg::TICK_BITS-1:0]  tick_cnt;
    logic [tws_pkg::BITC_BITS-1:0]  bit_cnt;
    logic [tws_pkg::SHIFT_BITS-1:0] shift_out;
    logic [tws_pkg::BYTE_BITS-1:0]  shift_in;
    logic [tws_pkg::TIME_BITS-1:0]  time_acc;
    logic [1:0]                     read_idx;
    tws_pkg::req_e                  kind;
    tws_pkg::res_t                  predicted_levels[$];
    int unsigned                    errors;
    int unsigned                    n_checked;

    function new();
      half_period = tws_pkg::HALF_PERIOD_RST;
      ce_setup    = tws_pkg::CE_SETUP_RST;
      phase       = LINK_IDLE;
      tick_cnt    = '0;
      bit_cnt     = '0;
      shift_out   = '0;
      shift_in    = '0;
      time_acc    = '0;
      read_idx    = '0;
      kind        = tws_pkg::REQ_NONE;
      errors      = 0;
      n_checked   = 0;
    endfunction

    function void write_reg(tws_pkg::cfg_idx_e idx, logic [tws_pkg::CFG_BITS-1:0] value);
      case (idx)
        tws_pkg::CFG_HALF_PERIOD: half_period = value[tws_pkg::HALF_BITS-1:0];
        default:                  ce_setup    = value[tws_pkg::TICK_BITS-1:0];
      endcase
    endfunction

    function bit link_busy();
      return phase != LINK_IDLE;
    endfunction

    function int pending();
      return predicted_levels.size();
    endfunction

    function void load_byte(logic [tws_pkg::SHIFT_BITS-1:0] bits);
      shift_out = bits;
      shift_in  = '0;
      bit_cnt   = '0;
      tick_cnt  = '0;
      phase     = LINK_SETUP;
    endfunction

    function void note_tick(tws_pkg::tick_t t);
      tws_pkg::res_t r;
      r = '0;
      if (phase == LINK_IDLE) begin
        if (t.req_type != tws_pkg::REQ_NONE) begin
          kind     = tws_pkg::req_e'(t.req_type);
          time_acc = '0;
          read_idx = '0;
          case (kind)
            tws_pkg::REQ_WRITE: load_byte({t.write_data, t.command});
            tws_pkg::REQ_READ:  load_byte({8'h00, t.command});
            default:            load_byte({8'h00, tws_pkg::CMD_HOUR});
          endcase
        end
      end else begin
        if (tick_cnt != tws_pkg::TICK_MAX) tick_cnt++;
        case (phase)
          LINK_SETUP: begin
            if (tick_cnt >= ce_setup) begin
              phase    = LINK_HIGH;
              tick_cnt = '0;
            end
          end
          LINK_HIGH: begin
            if (tick_cnt >= half_period) begin
              // read data is sampled at the end of each high phase of the second byte
              if (kind != tws_pkg::REQ_WRITE && bit_cnt >= tws_pkg::BYTE_BITS)
                shift_in[bit_cnt[2:0]] = shift_in[bit_cnt[2:0]] | t.data_in;
              else
                shift_out = shift_out >> 1;
              bit_cnt++;
              phase    = LINK_LOW;
              tick_cnt = '0;
            end
          end
          LINK_LOW: begin
            if (tick_cnt >= half_period) begin
              tick_cnt = '0;
              if (bit_cnt >= 2 * tws_pkg::BYTE_BITS) begin
                phase = LINK_IDLE;
                case (kind)
                  tws_pkg::REQ_READ: begin
                    r.done_res  = 1'b1;
                    r.read_data = {16'h0000, shift_in};
                  end
                  tws_pkg::REQ_WRITE: r.done_res = 1'b1;
                  default: begin
                    time_acc = {time_acc[15:0], shift_in};
                    read_idx++;
                    if (read_idx == 2'd3) begin
                      r.done_res  = 1'b1;
                      r.read_data = time_acc;
                    end else begin
                      phase = LINK_GAP;
                    end
                  end
                endcase
              end else begin
                phase = LINK_HIGH;
              end
            end
          end
          LINK_GAP: begin
            // CE low for one half period, then minutes, then seconds
            if (tick_cnt >= half_period)
              load_byte({8'h00, (read_idx == 2'd1) ? tws_pkg::CMD_MIN : tws_pkg::CMD_SEC});
          end
          default: begin
            phase    = LINK_IDLE;
            tick_cnt = '0;
          end
        endcase
      end
      r.ce         = (phase == LINK_SETUP || phase == LINK_HIGH || phase == LINK_LOW);
      r.sclk       = (phase == LINK_HIGH);
      r.data_drive = r.ce && (kind == tws_pkg::REQ_WRITE || bit_cnt < tws_pkg::BYTE_BITS);
      r.data_out   = r.data_drive & shift_out[0];
      r.busy_res   = (phase != LINK_IDLE);
      predicted_levels.push_back(r);
    endfunction

    function void check_field(string name, logic [tws_pkg::TIME_BITS-1:0] want,
                              logic [tws_pkg::TIME_BITS-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%s mismatch on result %0d: expected %0h, got %0h",
                   name, n_checked, want, got);
      end
    endfunction

    function void check_levels(tws_pkg::res_t got);
      tws_pkg::res_t want;
      if (predicted_levels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d arrived with nothing expected", n_checked);
        n_checked++;
        return;
      end
      want = predicted_levels.pop_front();
      check_field("ce", want.ce, got.ce);
      check_field("sclk", want.sclk, got.sclk);
      check_field("data_out", want.data_out, got.data_out);
      check_field("data_drive", want.data_drive, got.data_drive);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("done_res", want.done_res, got.done_res);
      check_field("read_data", want.read_data, got.read_data);
      n_checked++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tws_tick_if tick_ch ();
  tws_res_if  res_ch ();
  tws_cfg_if  cfg_ch ();

  link_scoreboard sb;

  // Idle/stall percentages for the current stimulus phase
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  three_wire_serial_master dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check on handshake, then pick next cycle's ready.
  // Values seen here are the ones from before this edge's register updates.
  always @(posedge clk_i) begin
    tws_pkg::res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.ce         = res_ch.ce;
      got.sclk       = res_ch.sclk;
      got.data_out   = res_ch.data_out;
      got.data_drive = res_ch.data_drive;
      got.busy_res   = res_ch.busy_res;
      got.done_res   = res_ch.done_res;
      got.read_data  = res_ch.read_data;
      sb.check_levels(got);
    end
    res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Hang detection: any transaction on any channel clears the count
  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else if (rst_ni)
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Random tick; start_pct is the chance that it carries a start request
  function automatic tws_pkg::tick_t random_tick(int start_pct);
    tws_pkg::tick_t t;
    t.req_type   = ($urandom_range(99) < start_pct) ? 2'($urandom_range(1, 3))
                                                    : tws_pkg::REQ_NONE;
    t.command    = 8'($urandom);
    t.write_data = 8'($urandom);
    t.data_in    = 1'($urandom_range(1));
    return t;
  endfunction

  // One tick transaction. Valid stays high from the previous tick unless an
  // idle gap is inserted, so back-to-back ticks never toggle valid in a step.
  task automatic drive_tick(tws_pkg::tick_t t);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.req_type   <= t.req_type;
    tick_ch.command    <= t.command;
    tick_ch.write_data <= t.write_data;
    tick_ch.data_in    <= t.data_in;
    do @(posedge clk_i); while (tick_ch.ready !== 1'b1);
    sb.note_tick(t);
  endtask

  // Hold the sender off until every predicted result has come back
  task automatic pause_sender();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Run the link to idle, drain the results, then give the output register
  // a few cycles so that nothing is in flight.
  task automatic settle_link();
    while (sb.link_busy()) drive_tick(random_tick(0));
    tick_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(logic [tws_pkg::CFG_BITS-1:0] half,
                            logic [tws_pkg::CFG_BITS-1:0] setup);
    logic [tws_pkg::CFG_BITS-1:0] vals [2];
    vals[0] = half;
    vals[1] = setup;
    settle_link();
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_ch.index <= tws_pkg::cfg_idx_e'(i);
      cfg_ch.data  <= vals[i];
      do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
      sb.write_reg(tws_pkg::cfg_idx_e'(i), vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Start one request from idle and tick until the link is idle again.
  // din_fill < 0 gives random data pin levels, else a constant level.
  // noisy puts start requests on the ticks while busy; they must be ignored.
  task automatic run_request(tws_pkg::req_e kind, logic [7:0] cmd, logic [7:0] wdat,
                             int din_fill, bit noisy);
    tws_pkg::tick_t t;
    t = random_tick(0);
    t.req_type   = kind;
    t.command    = cmd;
    t.write_data = wdat;
    if (din_fill >= 0) t.data_in = din_fill[0];
    drive_tick(t);
    while (sb.link_busy()) begin
      t = random_tick(noisy ? 50 : 0);
      if (din_fill >= 0) t.data_in = din_fill[0];
      drive_tick(t);
    end
  endtask

  // Random ticks: mostly start requests when idle, the odd ignored request
  // while busy. Timing is re-drawn every 65 ticks, kept short so that many
  // transactions fit.
  task automatic run_random(int n_ticks, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < n_ticks; i++) begin
      if (i % 65 == 0)
        set_timing(tws_pkg::CFG_BITS'($urandom_range(1, 3)),
                   tws_pkg::CFG_BITS'($urandom_range(1, 6)));
      if (i == n_ticks / 3) pause_sender();
      drive_tick(random_tick(sb.link_busy() ? 8 : 80));
    end
  endtask

  initial begin
    sb                 = new();
    rst_ni             = 1'b0;
    tick_ch.valid      = 1'b0;
    tick_ch.req_type   = tws_pkg::REQ_NONE;
    tick_ch.command    = '0;
    tick_ch.write_data = '0;
    tick_ch.data_in    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = tws_pkg::CFG_HALF_PERIOD;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    quiet_cycles       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset timing (18/67): read with the data pin held high
    run_request(tws_pkg::REQ_READ, 8'hFF, 8'h00, 1, 1'b0);

    // Shortest nonzero timing: data extremes, all request kinds
    set_timing(10'd1, 10'd1);
    run_request(tws_pkg::REQ_READ, 8'h00, 8'h00, 0, 1'b0);
    run_request(tws_pkg::REQ_WRITE, 8'hFF, 8'h00, -1, 1'b0);
    run_request(tws_pkg::REQ_WRITE, 8'h00, 8'hFF, -1, 1'b0);
    run_request(tws_pkg::REQ_TIME, 8'h00, 8'h00, -1, 1'b0);
    // starts arriving while busy must be dropped
    run_request(tws_pkg::REQ_READ, 8'hA5, 8'h00, -1, 1'b1);
    run_request(tws_pkg::REQ_WRITE, 8'h5A, 8'hC3, -1, 1'b1);
    run_request(tws_pkg::REQ_TIME, 8'h12, 8'h34, -1, 1'b1);

    // Zero timing registers: every phase lasts one tick
    set_timing(10'd0, 10'd0);
    run_request(tws_pkg::REQ_READ, 8'h81, 8'h00, -1, 1'b0);
    run_request(tws_pkg::REQ_TIME, 8'h00, 8'h00, -1, 1'b0);

    // Random part under each flow-control mix
    run_random(130, 0, 0);
    run_random(130, 65, 0);
    run_random(130, 0, 65);
    run_random(130, 34, 34);

    settle_link();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
